### rtl/core/bas_pkg.sv
// shared constants, types and cell link structure for the batch sorter
package bas_pkg;

    // number of cells in the chain, one stored value each
    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // control states of the sorter
    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } t_state;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } t_cell_op;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic                     gt;
    } t_cell_link;

endpackage

### rtl/core/batch_ascending_sorter.sv
// batch sorter top level: cell chain plus collect/drain control
//
// channel | direction | tdata             | tlast     | tuser
// s_axis  | in        | [31:0] value      | last      | -
// m_axis  | out       | [31:0] sorted val | final_res | [0] overflow
//
// collect: one input item per cycle, placed in order in the chain as it is
// accepted (dropped, setting overflow, if full); chain sorted at batch end.
// drain: a batch of n stored values leaves over n output items, one per
// accepted cycle, read from the head cell while the chain shifts toward it.
// s_axis_tready is low while draining; m_axis backpressure stalls the chain.
// reset (i_rst_n low, synchronous) empties all cells and clears the count.
module batch_ascending_sorter
    import bas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,  // [31:0] value
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,  // [31:0] sorted_value
    output logic              m_axis_tlast,
    output logic [0:0]        m_axis_tuser   // [0] overflow
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;
    t_cell_op         op;
    logic             in_acc;
    logic             out_acc;
    logic             room;
    t_cell_link       links [DEPTH];

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign room    = r_count < CNT_W'(DEPTH);

    // state, count and overflow registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // next state and chain operation
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_ovf         = r_ovf;
        op            = OP_HOLD;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (r_state)
            ST_COLLECT: begin
                s_axis_tready = 1'b1;
                if (in_acc) begin
                    if (room) begin
                        op      = OP_INSERT;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                m_axis_tvalid = 1'b1;
                if (out_acc) begin
                    op      = OP_SHIFT;
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = ST_COLLECT;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    // chain of cells, head cell holds the smallest value
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_link left;
        t_cell_link right;

        if (g == 0) begin : g_head
            assign left = '0;
        end else begin : g_mid_l
            assign left = links[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right = '0;
        end else begin : g_mid_r
            assign right = links[g+1];
        end

        bas_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (op),
            .i_x     ($signed(s_axis_tdata)),
            .i_left  (left),
            .i_right (right),
            .o_link  (links[g])
        );
    end

    // output item comes straight from the head cell register
    assign m_axis_tdata = links[0].value;
    assign m_axis_tlast = (r_count == CNT_W'(1));
    assign m_axis_tuser = r_ovf;

endmodule

### rtl/core/bas_cell.sv
// one cell of the insertion chain: holds a value and shifts it to neighbors
module bas_cell
    import bas_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_op                 i_op,
    input  logic signed [DATA_W-1:0] i_x,
    input  t_cell_link               i_left,
    input  t_cell_link               i_right,
    output t_cell_link               o_link
);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_value;
    logic                     n_valid;
    logic signed [DATA_W-1:0] n_value;
    logic                     gt;

    // an empty cell counts as larger than any incoming value
    assign gt = !r_valid || (r_value > i_x);

    // next contents: keep, take incoming item, take left, or take right
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        unique case (i_op)
            OP_INSERT: begin
                if (gt) begin
                    if (i_left.gt) begin
                        n_valid = i_left.valid;
                        n_value = i_left.value;
                    end else begin
                        n_valid = 1'b1;
                        n_value = i_x;
                    end
                end
            end
            OP_SHIFT: begin
                n_valid = i_right.valid;
                n_value = i_right.value;
            end
            default: begin
                n_valid = r_valid;
                n_value = r_value;
            end
        endcase
    end

    // valid bit is control, value is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link = '{valid: r_valid, value: r_value, gt: gt};

endmodule
